/* src/upr_pkg.sv */
package upr_pkg;

  localparam int TimerBitsDef = 16;

  localparam int CfgIdxW  = 8;
  localparam int CfgDataW = 16;
  localparam int DistW    = 11;

  // register indexes
  localparam logic [CfgIdxW-1:0] CFG_PRELOW  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CFG_TRIGGER = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] CFG_TIMEOUT = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] CFG_HOLDOFF = CfgIdxW'(3);

  localparam logic [7:0]  PrelowRst  = 8'd2;
  localparam logic [7:0]  TriggerRst = 8'd5;
  localparam logic [15:0] TimeoutRst = 16'd20000;
  localparam logic [15:0] HoldoffRst = 16'd200;

  // distance = width / 58 = (width >> 1) / 29, 16-bit dividend by reciprocal
  localparam int UsPerCm  = 58;
  localparam int DistMax  = 2047;
  localparam int DivRecip = 72316;
  localparam int DivShift = 21;

  typedef struct packed {
    logic [7:0]  prelow_us;
    logic [7:0]  trigger_us;
    logic [15:0] timeout_us;
    logic [15:0] holdoff_us;
  } cfg_t;

  typedef struct packed {
    logic             pin_is_output;
    logic             pin_drive_high;
    logic             busy_res;
    logic             done_res;
    logic             timed_out;
    logic [DistW-1:0] distance_cm;
  } res_t;

endpackage

/* src/upr_if.sv */
interface upr_req_if;
  logic valid;
  logic ready;
  logic start_req;
  logic echo_level;

  modport source (output valid, output start_req, output echo_level, input ready);
  modport sink (input valid, input start_req, input echo_level, output ready);
endinterface

interface upr_res_if;
  logic                       valid;
  logic                       ready;
  logic                       pin_is_output;
  logic                       pin_drive_high;
  logic                       busy_res;
  logic                       done_res;
  logic                       timed_out;
  logic [upr_pkg::DistW-1:0]  distance_cm;

  modport source (output valid, output pin_is_output, output pin_drive_high,
                  output busy_res, output done_res, output timed_out,
                  output distance_cm, input ready);
  modport sink (input valid, input pin_is_output, input pin_drive_high,
                input busy_res, input done_res, input timed_out,
                input distance_cm, output ready);
endinterface

interface upr_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [upr_pkg::CfgIdxW-1:0]   index;
  logic [upr_pkg::CfgDataW-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* src/upr_dist58.sv */
module upr_dist58 #(
  parameter int TIMER_BITS = upr_pkg::TimerBitsDef
) (
  input  logic [TIMER_BITS-1:0]      width_i,
  output logic [upr_pkg::DistW-1:0]  dist_o
);
  import upr_pkg::*;

  localparam logic [32:0] SatWidth = 33'((DistMax + 1) * UsPerCm);

  logic [32:0] w_ext;
  logic [15:0] half_w;
  logic [32:0] prod;

  assign w_ext  = 33'(width_i);
  assign half_w = w_ext[16:1];
  assign prod   = 33'(half_w) * 33'(DivRecip);

  always_comb begin
    if (w_ext >= SatWidth) begin
      dist_o = DistW'(DistMax);
    end else begin
      dist_o = prod[DivShift+DistW-1:DivShift];
    end
  end

endmodule

/* src/upr_core.sv */
module upr_core #(
  parameter int TIMER_BITS = upr_pkg::TimerBitsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  upr_pkg::cfg_t cfg_i,
  input  logic          step_i,
  input  logic          start_req_i,
  input  logic          echo_level_i,
  output upr_pkg::res_t res_o
);
  import upr_pkg::*;

  localparam int CmpW = (TIMER_BITS > 16) ? TIMER_BITS : 16;
  localparam logic [TIMER_BITS-1:0] CntMax = {TIMER_BITS{1'b1}};

  typedef enum logic [5:0] {
    PH_IDLE      = 6'b000001,
    PH_PRELOW    = 6'b000010,
    PH_TRIGGER   = 6'b000100,
    PH_WAIT_RISE = 6'b001000,
    PH_ECHO      = 6'b010000,
    PH_HOLDOFF   = 6'b100000
  } phase_e;

  phase_e                phase_q, phase_d;
  logic [TIMER_BITS-1:0] count_q, count_d;
  logic [TIMER_BITS-1:0] width_q, width_d;
  logic                  tflag_q, tflag_d;
  logic [DistW-1:0]      dist_calc;

  upr_dist58 #(.TIMER_BITS(TIMER_BITS)) u_dist (
    .width_i (width_q),
    .dist_o  (dist_calc)
  );

  function automatic logic limit_hit(logic [TIMER_BITS-1:0] v, logic [15:0] lim);
    return (CmpW'(v) >= CmpW'(lim)) || (v == CntMax);
  endfunction

  function automatic logic [TIMER_BITS-1:0] sat_inc(logic [TIMER_BITS-1:0] v);
    return (v == CntMax) ? v : v + TIMER_BITS'(1);
  endfunction

  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    width_d = width_q;
    tflag_d = tflag_q;
    res_o   = '0;

    case (phase_q)
      PH_IDLE, PH_PRELOW, PH_TRIGGER, PH_WAIT_RISE, PH_ECHO, PH_HOLDOFF: begin
        phase_d = phase_q;
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase

    if (phase_d == PH_IDLE && start_req_i) begin
      phase_d = PH_PRELOW;
      count_d = '0;
      width_d = '0;
      tflag_d = 1'b0;
    end

    if (phase_d == PH_PRELOW) begin
      if (CmpW'(count_d) < CmpW'(cfg_i.prelow_us)) begin
        res_o.pin_is_output = 1'b1;
        count_d = count_d + TIMER_BITS'(1);
      end else begin
        phase_d = PH_TRIGGER;
        count_d = '0;
      end
    end

    if (phase_d == PH_TRIGGER && !res_o.pin_is_output) begin
      if (CmpW'(count_d) < CmpW'(cfg_i.trigger_us)) begin
        res_o.pin_is_output  = 1'b1;
        res_o.pin_drive_high = 1'b1;
        count_d = count_d + TIMER_BITS'(1);
      end else begin
        phase_d = PH_WAIT_RISE;
        count_d = '0;
      end
    end

    if (phase_d == PH_IDLE) begin
      res_o.busy_res = 1'b0;
    end else if (res_o.pin_is_output) begin
      res_o.busy_res = 1'b1;
    end else if (phase_d == PH_WAIT_RISE) begin
      res_o.busy_res = 1'b1;
      if (echo_level_i) begin
        phase_d = PH_ECHO;
        width_d = TIMER_BITS'(1);
        if (limit_hit(width_d, cfg_i.timeout_us)) begin
          tflag_d = 1'b1;
          width_d = '0;
          phase_d = PH_HOLDOFF;
          count_d = '0;
        end
      end else begin
        count_d = sat_inc(count_d);
        if (limit_hit(count_d, cfg_i.timeout_us)) begin
          tflag_d = 1'b1;
          width_d = '0;
          phase_d = PH_HOLDOFF;
          count_d = '0;
        end
      end
    end else if (phase_d == PH_ECHO) begin
      res_o.busy_res = 1'b1;
      if (echo_level_i) begin
        width_d = sat_inc(width_d);
        if (limit_hit(width_d, cfg_i.timeout_us)) begin
          tflag_d = 1'b1;
          width_d = '0;
          phase_d = PH_HOLDOFF;
          count_d = '0;
        end
      end else begin
        phase_d = PH_HOLDOFF;
        count_d = '0;
      end
    end else if (phase_d == PH_HOLDOFF) begin
      if (CmpW'(count_d) >= CmpW'(cfg_i.holdoff_us)) begin
        // width and flag are untouched in holdoff, so the stored values apply
        res_o.done_res  = 1'b1;
        res_o.timed_out = tflag_q;
        if (!tflag_q) begin
          res_o.distance_cm = dist_calc;
        end
        phase_d = PH_IDLE;
        count_d = '0;
      end else begin
        res_o.busy_res = 1'b1;
        count_d = sat_inc(count_d);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      count_q <= '0;
      width_q <= '0;
      tflag_q <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      count_q <= count_d;
      width_q <= width_d;
      tflag_q <= tflag_d;
    end
  end

endmodule

/* src/ultrasonic_ping_ranger.sv */
// channel   dir  handshake     payload
// req_chan  in   valid/ready   start_req, echo_level (one microsecond tick)
// res_chan  out  valid/ready   pin_is_output, pin_drive_high, busy_res, done_res,
//                              timed_out, distance_cm
// cfg_chan  in   valid/ready   index, data (ready always high)
//
// One tick request accepted per cycle while the skid entry is empty; its result is registered.
// The ranging state updates in the accepting cycle, so tick N+1 follows tick N directly.
// A two-entry output stage (output register plus skid) keeps accepting while a
// result waits; req ready drops only once both entries are full.
// Reset clears the phase, counters and configuration to defaults; no clearing pass.
module ultrasonic_ping_ranger #(
  parameter int TIMER_BITS = upr_pkg::TimerBitsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  upr_req_if.sink   req_chan,
  upr_res_if.source res_chan,
  upr_cfg_if.sink   cfg_chan
);
  import upr_pkg::*;

  cfg_t cfg_q, cfg_d;
  res_t step_res;
  res_t out_q, out_d;
  res_t skid_q, skid_d;
  logic out_valid_q, out_valid_d;
  logic skid_valid_q, skid_valid_d;
  logic accept;
  logic take;

  assign cfg_chan.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_chan.valid) begin
      case (cfg_chan.index)
        CFG_PRELOW:  cfg_d.prelow_us  = cfg_chan.data[7:0];
        CFG_TRIGGER: cfg_d.trigger_us = cfg_chan.data[7:0];
        CFG_TIMEOUT: cfg_d.timeout_us = cfg_chan.data;
        CFG_HOLDOFF: cfg_d.holdoff_us = cfg_chan.data;
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{prelow_us: PrelowRst, trigger_us: TriggerRst,
                 timeout_us: TimeoutRst, holdoff_us: HoldoffRst};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign req_chan.ready = !skid_valid_q;
  assign accept         = req_chan.valid && !skid_valid_q;
  assign take           = out_valid_q && res_chan.ready;

  upr_core #(.TIMER_BITS(TIMER_BITS)) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .step_i       (accept),
    .start_req_i  (req_chan.start_req),
    .echo_level_i (req_chan.echo_level),
    .res_o        (step_res)
  );

  always_comb begin
    out_d        = out_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (take) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else if (accept) begin
        out_d = step_res;
      end else begin
        out_valid_d = 1'b0;
      end
    end else if (accept) begin
      if (!out_valid_q) begin
        out_d       = step_res;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = step_res;
        skid_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign res_chan.valid          = out_valid_q;
  assign res_chan.pin_is_output  = out_q.pin_is_output;
  assign res_chan.pin_drive_high = out_q.pin_drive_high;
  assign res_chan.busy_res       = out_q.busy_res;
  assign res_chan.done_res       = out_q.done_res;
  assign res_chan.timed_out      = out_q.timed_out;
  assign res_chan.distance_cm    = out_q.distance_cm;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held with empty output register");

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.done_res |-> !out_q.busy_res && !out_q.pin_is_output)
    else $error("done request also flagged busy or driving");

  a_timeout_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.timed_out |-> out_q.done_res && (out_q.distance_cm == '0))
    else $error("timed out request with distance or without done");

  a_drive_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.pin_drive_high |-> out_q.pin_is_output && out_q.busy_res)
    else $error("pin high without drive enable");

endmodule
